>>> hw/rtl/chunk_transfer_receiver_tracker_assert.svh
// Assertion macros for the chunk transfer receiver tracker.
`ifndef CHUNK_TRANSFER_RECEIVER_TRACKER_ASSERT_SVH
`define CHUNK_TRANSFER_RECEIVER_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ctrt assertion failed");

// Next-cycle implication, checked outside reset.
`define CTRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ctrt assertion failed");

`endif

>>> hw/rtl/ctrt_pkg.sv
// Types and constants of the chunk transfer receiver tracker.
package ctrt_pkg;

	localparam int ROW_W   = 32;
	localparam int ROW_BW  = 5;
	localparam int RES_CAP = 32;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_END   = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		K_START_ACK = 3'd0,
		K_DATA_NEW  = 3'd1,
		K_DATA_DUP  = 3'd2,
		K_NAK       = 3'd3,
		K_PASS      = 3'd4,
		K_FAIL      = 3'd5,
		K_REJECT    = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		PH_WAIT = 3'b001,
		PH_RECV = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef enum logic [5:0] {
		S_CLEAR     = 6'b000001,
		S_IDLE      = 6'b000010,
		S_EXEC      = 6'b000100,
		S_SCAN_LOAD = 6'b001000,
		S_SCAN_BIT  = 6'b010000,
		S_SCAN_END  = 6'b100000
	} state_t;

endpackage

>>> hw/rtl/ctrt_if.sv
// Valid/ready channels carrying input items and result items.
interface ctrt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] xfer_id;
	logic [31:0] chunk_seq;
	logic [31:0] chunk_count;
	logic [63:0] start_nonce;
	logic [15:0] candidate_id;
	logic        crc_ok;

	modport source (output valid, opcode, xfer_id, chunk_seq, chunk_count, start_nonce,
		candidate_id, crc_ok, input ready);
	modport sink (input valid, opcode, xfer_id, chunk_seq, chunk_count, start_nonce,
		candidate_id, crc_ok, output ready);
endinterface

interface ctrt_out_if;
	import ctrt_pkg::*;
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [15:0] ack_transfer_id;
	logic [63:0] echo_nonce;
	logic [11:0] missing_seq;
	logic [12:0] received_count;
	logic        last;

	modport source (output valid, kind, ack_transfer_id, echo_nonce, missing_seq,
		received_count, last, input ready);
	modport sink (input valid, kind, ack_transfer_id, echo_nonce, missing_seq,
		received_count, last, output ready);
endinterface

>>> hw/rtl/chunk_transfer_receiver_tracker.sv
// Receiver tracker for a chunked transfer: chunk bitmap memory and item sequencer.
//
// Channels: req (sink) takes START, DATA and END beats; rsp (source) gives result
// beats, one or more per item, the final one of an item marked by last.
// One item is handled at a time. The chunk bitmap lives in a memory of 32-bit
// rows with a registered read: an item's row is read as the beat is taken and
// evaluated in S_EXEC, and req.ready stays low until the item is done.
// A START that opens, rejects or a failed END also sweeps the bitmap clear,
// one row a cycle over all ceil(MAX_CHUNKS/32) rows (128 at the defaults), while
// req.ready stays low.
// An END with missing chunks scans the bitmap from row 0: each row is loaded in
// S_SCAN_LOAD and searched in S_SCAN_BIT up to the last announced chunk or the row
// that fills the nak cap, and S_SCAN_END gives the last of at most min(NAK_LIMIT, 32) nak beats.
// Reset clears the control state and the output valid flag and starts the same
// clearing sweep before the first beat is taken.
// A result waits in an output register; a new item is accepted while it waits,
// but the next result holds the sequencer until rsp.ready takes the old one.
// Ignored items (stray data or end, unused opcode) give no result beat.
module chunk_transfer_receiver_tracker #(
	parameter int MAX_CHUNKS = 4096,
	parameter int NAK_LIMIT  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	ctrt_in_if.sink           req,
	ctrt_out_if.source        rsp
);
	import ctrt_pkg::*;

	localparam int ROWS    = (MAX_CHUNKS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SEQ_W   = ROW_AW + ROW_BW;
	localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
	localparam int NAK_CAP = (NAK_LIMIT < RES_CAP) ? NAK_LIMIT : RES_CAP;
	localparam int NCNT_W  = $clog2(NAK_CAP + 1);

	// bitmap memory
	logic [ROW_W-1:0]  mem [ROWS];
	logic [ROW_W-1:0]  rd_data_q;
	logic              rd_en, wr_en;
	logic [ROW_AW-1:0] rd_addr, wr_addr;
	logic [ROW_W-1:0]  wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// control state
	state_t            state_q;
	phase_t            phase_q;
	logic [15:0]       cur_id_q;
	logic [63:0]       nonce_q;
	logic [CNT_W-1:0]  chunk_total_q;
	logic [CNT_W-1:0]  recv_total_q;
	logic [ROW_AW-1:0] clr_q;
	logic [ROW_AW-1:0] row_q;
	logic [NCNT_W-1:0] nak_cnt_q;
	logic              pend_valid_q;
	logic [SEQ_W-1:0]  pend_seq_q;
	logic [ROW_W-1:0]  miss_q;

	// held item
	logic [1:0]        it_op_q;
	logic [15:0]       it_tid_q;
	logic [31:0]       it_seq_q;
	logic [31:0]       it_count_q;
	logic [63:0]       it_nonce_q;
	logic [15:0]       it_cand_q;
	logic              it_crc_q;

	// output register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [15:0]       out_id_q;
	logic [63:0]       out_nonce_q;
	logic [11:0]       out_miss_q;
	logic [12:0]       out_cnt_q;
	logic              out_last_q;

	logic              accept, out_free, id_match;
	logic              start_rep, start_rej, data_ok, bit_set, end_done, end_recv, end_nak;
	logic [15:0]       fresh_id;
	logic [ROW_AW-1:0] last_row;
	logic [31:0]       rem;
	logic [ROW_W-1:0]  range_mask;
	logic [ROW_BW-1:0] low_bit;
	logic [31:0]       total_m1, pend_ext, recv_ext;

	logic              emit;
	kind_t             e_kind;
	logic [15:0]       e_id;
	logic [63:0]       e_nonce;
	logic [11:0]       e_miss;
	logic              e_last;
	logic [CNT_W-1:0]  e_cnt;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign id_match  = (it_tid_q == cur_id_q);

	assign start_rep = (it_op_q == OP_START) && (phase_q == PH_RECV) && (it_nonce_q == nonce_q);
	assign start_rej = (it_op_q == OP_START) && !start_rep && (it_count_q > 32'(MAX_CHUNKS));
	assign data_ok   = (it_op_q == OP_DATA) && (phase_q == PH_RECV) && id_match
		&& (it_seq_q < 32'(chunk_total_q));
	assign bit_set   = rd_data_q[it_seq_q[ROW_BW-1:0]];
	assign end_done  = (it_op_q == OP_END) && (phase_q == PH_DONE) && id_match;
	assign end_recv  = (it_op_q == OP_END) && (phase_q == PH_RECV) && id_match;
	assign end_nak   = end_recv && (recv_total_q < chunk_total_q);
	assign fresh_id  = (it_cand_q == 16'd0) ? 16'd1 : it_cand_q;

	assign total_m1  = 32'(chunk_total_q) - 32'd1;
	assign last_row  = total_m1[SEQ_W-1:ROW_BW];
	assign pend_ext  = 32'(pend_seq_q);
	assign recv_ext  = 32'(recv_total_q);

	// chunks of the current row that lie below the announced count
	always_comb begin
		rem = 32'(chunk_total_q) - (32'(row_q) << ROW_BW);
		if (rem >= 32'(ROW_W)) begin
			range_mask = '1;
		end else begin
			range_mask = (ROW_W'(1) << rem[ROW_BW-1:0]) - ROW_W'(1);
		end
	end

	// lowest missing chunk of the row
	always_comb begin
		low_bit = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (miss_q[b]) begin
				low_bit = ROW_BW'(b);
			end
		end
	end

	// memory ports and result selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = req.chunk_seq[SEQ_W-1:ROW_BW];
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		emit    = 1'b0;
		e_kind  = K_START_ACK;
		e_id    = cur_id_q;
		e_nonce = 64'd0;
		e_miss  = 12'd0;
		e_cnt   = recv_total_q;
		e_last  = 1'b1;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en = accept;
			end
			S_EXEC: begin
				if (out_free) begin
					case (it_op_q)
						OP_START: begin
							emit    = 1'b1;
							e_nonce = it_nonce_q;
							if (start_rep) begin
								e_kind = K_START_ACK;
							end else if (start_rej) begin
								e_kind = K_REJECT;
								e_id   = 16'd0;
								e_cnt  = '0;
							end else begin
								e_kind = K_START_ACK;
								e_id   = fresh_id;
								e_cnt  = '0;
							end
						end
						OP_DATA: begin
							if (data_ok) begin
								emit = 1'b1;
								if (bit_set) begin
									e_kind = K_DATA_DUP;
								end else begin
									e_kind  = K_DATA_NEW;
									e_cnt   = recv_total_q + CNT_W'(1);
									wr_en   = 1'b1;
									wr_addr = it_seq_q[SEQ_W-1:ROW_BW];
									wr_data = rd_data_q | (ROW_W'(1) << it_seq_q[ROW_BW-1:0]);
								end
							end
						end
						OP_END: begin
							if (end_done) begin
								emit   = 1'b1;
								e_kind = K_PASS;
							end else if (end_nak) begin
								rd_en   = 1'b1;
								rd_addr = '0;
							end else if (end_recv) begin
								emit   = 1'b1;
								e_kind = it_crc_q ? K_PASS : K_FAIL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN_BIT: begin
				if (miss_q == '0) begin
					if (row_q != last_row) begin
						rd_en   = 1'b1;
						rd_addr = row_q + ROW_AW'(1);
					end
				end else if (pend_valid_q && out_free) begin
					emit   = 1'b1;
					e_kind = K_NAK;
					e_miss = pend_ext[11:0];
					e_last = 1'b0;
				end
			end
			S_SCAN_END: begin
				if (out_free) begin
					emit   = 1'b1;
					e_kind = K_NAK;
					e_miss = pend_ext[11:0];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			phase_q       <= PH_WAIT;
			cur_id_q      <= '0;
			nonce_q       <= '0;
			chunk_total_q <= '0;
			recv_total_q  <= '0;
			clr_q         <= '0;
			row_q         <= '0;
			nak_cnt_q     <= '0;
			pend_valid_q  <= 1'b0;
			pend_seq_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_q == ROW_AW'(ROWS - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + ROW_AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (it_op_q)
							OP_START: begin
								if (!start_rep) begin
									state_q      <= S_CLEAR;
									recv_total_q <= '0;
									if (start_rej) begin
										phase_q       <= PH_WAIT;
										cur_id_q      <= '0;
										nonce_q       <= '0;
										chunk_total_q <= '0;
									end else begin
										phase_q       <= PH_RECV;
										cur_id_q      <= fresh_id;
										nonce_q       <= it_nonce_q;
										chunk_total_q <= it_count_q[CNT_W-1:0];
									end
								end
							end
							OP_DATA: begin
								if (data_ok && !bit_set) begin
									recv_total_q <= recv_total_q + CNT_W'(1);
								end
							end
							OP_END: begin
								if (end_nak) begin
									row_q        <= '0;
									nak_cnt_q    <= '0;
									pend_valid_q <= 1'b0;
									state_q      <= S_SCAN_LOAD;
								end else if (end_recv && !end_done) begin
									if (it_crc_q) begin
										phase_q <= PH_DONE;
									end else begin
										// failed check drops the whole context
										phase_q       <= PH_WAIT;
										cur_id_q      <= '0;
										nonce_q       <= '0;
										chunk_total_q <= '0;
										recv_total_q  <= '0;
										state_q       <= S_CLEAR;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN_LOAD: begin
					state_q <= S_SCAN_BIT;
				end
				S_SCAN_BIT: begin
					if (miss_q == '0) begin
						if (row_q == last_row) begin
							state_q <= S_SCAN_END;
						end else begin
							row_q   <= row_q + ROW_AW'(1);
							state_q <= S_SCAN_LOAD;
						end
					end else if (!pend_valid_q || out_free) begin
						// hold the newest nak until the next one shows whether it is last
						pend_valid_q <= 1'b1;
						pend_seq_q   <= {row_q, low_bit};
						nak_cnt_q    <= nak_cnt_q + NCNT_W'(1);
						if (nak_cnt_q + NCNT_W'(1) == NCNT_W'(NAK_CAP)) begin
							state_q <= S_SCAN_END;
						end
					end
				end
				S_SCAN_END: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture and row miss mask
	always_ff @(posedge clk) begin
		if (accept) begin
			it_op_q    <= req.opcode;
			it_tid_q   <= req.xfer_id;
			it_seq_q   <= req.chunk_seq;
			it_count_q <= req.chunk_count;
			it_nonce_q <= req.start_nonce;
			it_cand_q  <= req.candidate_id;
			it_crc_q   <= req.crc_ok;
		end
		if (state_q == S_SCAN_LOAD) begin
			miss_q <= ~rd_data_q & range_mask;
		end else if (state_q == S_SCAN_BIT && miss_q != '0 && (!pend_valid_q || out_free)) begin
			miss_q <= miss_q & (miss_q - ROW_W'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= e_kind;
			out_id_q    <= e_id;
			out_nonce_q <= e_nonce;
			out_miss_q  <= e_miss;
			out_cnt_q   <= recv_ext[12:0] + 13'd0 + (13'(32'(e_cnt)) - recv_ext[12:0]);
			out_last_q  <= e_last;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.kind            = out_kind_q;
	assign rsp.ack_transfer_id = out_id_q;
	assign rsp.echo_nonce      = out_nonce_q;
	assign rsp.missing_seq     = out_miss_q;
	assign rsp.received_count  = out_cnt_q;
	assign rsp.last            = out_last_q;

	`include "chunk_transfer_receiver_tracker_assert.svh"

	`CTRT_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, recv_total_q <= chunk_total_q)
	`CTRT_ASSERT_NOW(a_done_full, clk, arst_n, phase_q == PH_DONE,
		recv_total_q == chunk_total_q)
	`CTRT_ASSERT_NOW(a_nak_cap, clk, arst_n, 1'b1, nak_cnt_q <= NCNT_W'(NAK_CAP))
	`CTRT_ASSERT_NEXT(a_clear_blocks, clk, arst_n, state_q == S_CLEAR && clr_q != '0,
		!$past(req.ready))

endmodule

>>> tb/sv/tb_chunk_transfer_receiver_tracker.sv
// Testbench of the chunk transfer receiver tracker: directed and random item streams.
`timescale 1ns / 100ps

module tb_chunk_transfer_receiver_tracker;
	import ctrt_pkg::*;

	localparam int MAX_CHUNKS  = 4096;
	localparam int NAK_LIMIT   = 32;
	localparam int NAK_CAP     = (NAK_LIMIT < RES_CAP) ? NAK_LIMIT : RES_CAP;
	localparam int STALL_LIMIT = 3000;
	localparam int LIVE_ITEMS  = 250;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] tid;
		logic [31:0] seq;
		logic [31:0] count;
		logic [63:0] nonce;
		logic [15:0] cand;
		logic        crc;
	} chunk_item_t;

	typedef struct {
		kind_t       kind;
		logic [15:0] id;
		logic [63:0] nonce;
		logic [11:0] miss;
		logic [12:0] rcvd;
		logic        last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	ctrt_in_if  req_if ();
	ctrt_out_if rsp_if ();

	chunk_transfer_receiver_tracker #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.NAK_LIMIT (NAK_LIMIT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always #5 clk = ~clk;

	// local copy of the receiver context
	phase_t      rx_phase;
	logic [15:0] rx_id;
	logic [63:0] rx_nonce;
	logic [12:0] rx_total;
	logic [12:0] rx_count;
	bit          rx_map [MAX_CHUNKS];

	reply_t reply_q [$];
	int     errs;
	int     n_sent;
	int     hold_cycles;
	bit     no_idle;
	int     idle_cycles = 0;

	function automatic void wipe_context();
		rx_phase = PH_WAIT;
		rx_id    = '0;
		rx_nonce = '0;
		rx_total = '0;
		rx_count = '0;
		for (int i = 0; i < MAX_CHUNKS; i++)
			rx_map[i] = 1'b0;
	endfunction

	function automatic void post_reply(kind_t k, logic [15:0] id, logic [63:0] n,
		logic [11:0] m, logic [12:0] c, logic l);
		reply_t r;
		r.kind  = k;
		r.id    = id;
		r.nonce = n;
		r.miss  = m;
		r.rcvd  = c;
		r.last  = l;
		reply_q.push_back(r);
	endfunction

	// advance the context by one accepted item and queue the replies it causes
	function automatic void update_transfer(chunk_item_t it);
		int n;
		case (it.op)
			OP_START: begin
				if (rx_phase == PH_RECV && it.nonce == rx_nonce) begin
					post_reply(K_START_ACK, rx_id, it.nonce, '0, rx_count, 1'b1);
				end else begin
					wipe_context();
					if (it.count > MAX_CHUNKS) begin
						post_reply(K_REJECT, '0, it.nonce, '0, '0, 1'b1);
					end else begin
						rx_nonce = it.nonce;
						rx_total = it.count[12:0];
						rx_id    = (it.cand != 0) ? it.cand : 16'd1;
						rx_phase = PH_RECV;
						post_reply(K_START_ACK, rx_id, it.nonce, '0, '0, 1'b1);
					end
				end
			end
			OP_DATA: begin
				if (rx_phase == PH_RECV && it.tid == rx_id && it.seq < rx_total) begin
					if (!rx_map[it.seq[11:0]]) begin
						rx_map[it.seq[11:0]] = 1'b1;
						rx_count++;
						post_reply(K_DATA_NEW, rx_id, '0, '0, rx_count, 1'b1);
					end else begin
						post_reply(K_DATA_DUP, rx_id, '0, '0, rx_count, 1'b1);
					end
				end
			end
			OP_END: begin
				if (rx_phase == PH_DONE) begin
					if (it.tid == rx_id)
						post_reply(K_PASS, rx_id, '0, '0, rx_count, 1'b1);
				end else if (rx_phase == PH_RECV && it.tid == rx_id) begin
					if (rx_count < rx_total) begin
						n = 0;
						for (int i = 0; i < rx_total && n < NAK_CAP; i++) begin
							if (!rx_map[i]) begin
								post_reply(K_NAK, rx_id, '0, i[11:0], rx_count, 1'b0);
								n++;
							end
						end
						reply_q[$].last = 1'b1;
					end else if (it.crc) begin
						rx_phase = PH_DONE;
						post_reply(K_PASS, rx_id, '0, '0, rx_count, 1'b1);
					end else begin
						post_reply(K_FAIL, rx_id, '0, '0, rx_count, 1'b1);
						wipe_context();
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic chunk_item_t rand_item(logic [1:0] op);
		chunk_item_t it;
		it.op    = op;
		it.tid   = 16'($urandom_range(0, 65535));
		it.seq   = $urandom;
		it.count = $urandom;
		it.nonce = {$urandom, $urandom};
		it.cand  = 16'($urandom_range(0, 65535));
		it.crc   = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// drive one beat from the falling edge and hold it until the block takes it
	task automatic send_item(chunk_item_t it);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 99) < 21) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_if.valid        = 1'b1;
		req_if.opcode       = it.op;
		req_if.xfer_id      = it.tid;
		req_if.chunk_seq    = it.seq;
		req_if.chunk_count  = it.count;
		req_if.start_nonce  = it.nonce;
		req_if.candidate_id = it.cand;
		req_if.crc_ok       = it.crc;
		do @(posedge clk); while (!req_if.ready);
		n_sent++;
		update_transfer(it);
	endtask

	task automatic send_start(logic [31:0] count, logic [15:0] cand, logic [63:0] nonce);
		chunk_item_t it;
		it       = rand_item(OP_START);
		it.count = count;
		it.cand  = cand;
		it.nonce = nonce;
		send_item(it);
	endtask

	task automatic send_data(logic [15:0] tid, logic [31:0] seq);
		chunk_item_t it;
		it     = rand_item(OP_DATA);
		it.tid = tid;
		it.seq = seq;
		send_item(it);
	endtask

	task automatic send_end(logic [15:0] tid, logic crc);
		chunk_item_t it;
		it     = rand_item(OP_END);
		it.tid = tid;
		it.crc = crc;
		send_item(it);
	endtask

	// items the block should drop: foreign ids, stray chunk numbers, unused opcode
	task automatic send_noise();
		chunk_item_t it;
		case ($urandom_range(0, 4))
			0: begin
				it     = rand_item(OP_DATA);
				it.tid = rx_id ^ 16'($urandom_range(1, 65535));
			end
			1: begin
				it     = rand_item(OP_DATA);
				it.tid = rx_id;
				it.seq = 32'(rx_total) + $urandom_range(0, 3);
			end
			2: begin
				it     = rand_item(OP_DATA);
				it.tid = rx_id;
				it.seq = $urandom | 32'h0000_1000;
			end
			3: begin
				it     = rand_item(OP_END);
				it.tid = rx_id ^ 16'($urandom_range(1, 65535));
			end
			default: it = rand_item(OP_UNUSED);
		endcase
		send_item(it);
	endtask

	task automatic wait_replies();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_stray_items();
		send_end(16'd0, 1'b1);
		send_data(16'd0, 32'd0);
		send_item(rand_item(OP_UNUSED));
	endtask

	task automatic test_start_limits();
		send_start(32'd4097, 16'h1234, '1);
		send_start(32'hFFFF_FFFF, 16'hFFFF, 64'h8000_0000_0000_0001);
		// empty transfer with id zero offered, then an end with a bad CRC
		send_start(32'd0, 16'd0, 64'd0);
		send_end(16'd1, 1'b0);
	endtask

	task automatic test_full_range();
		send_start(32'd4096, 16'hFFFF, '1);
		send_data(rx_id, 32'd0);
		send_data(rx_id, 32'd4095);
		send_data(rx_id, 32'd4095);
		send_data(rx_id, 32'd4096);
		send_data(rx_id, 32'hFFFF_FFFF);
		send_data(rx_id ^ 16'h0001, 32'd1);
		send_start(32'd7, 16'h0042, '1);
		send_end(rx_id, 1'b1);
	endtask

	task automatic test_pass_path();
		send_start(32'd3, 16'd5, 64'h0123_4567_89AB_CDEF);
		for (int i = 0; i < 3; i++)
			send_data(rx_id, i);
		send_end(rx_id, 1'b1);
		send_end(rx_id, 1'b0);
		send_end(rx_id ^ 16'h8000, 1'b1);
		send_data(rx_id, 32'd0);
		// same nonce once done opens a fresh transfer
		send_start(32'd1, 16'd0, 64'h0123_4567_89AB_CDEF);
	endtask

	task automatic test_burst();
		no_idle = 1'b1;
		send_start(32'd40, 16'($urandom_range(1, 65535)), {$urandom, $urandom});
		for (int i = 0; i < 40; i++)
			send_data(rx_id, i);
		send_end(rx_id, 1'b1);
		wait_replies();
		no_idle = 1'b0;
	endtask

	task automatic test_output_stall();
		hold_cycles = 300;
		send_start(32'd30, 16'($urandom_range(1, 65535)), {$urandom, $urandom});
		for (int i = 0; i < 30; i++)
			send_data(rx_id, i);
		send_end(rx_id, 1'b1);
		wait_replies();
	endtask

	task automatic run_transfer();
		int pick, cnt, j, k, tmp;
		int order [$];
		logic [31:0] big;
		logic [63:0] nc;
		pick = $urandom_range(0, 99);
		nc   = {$urandom, $urandom};
		if (pick < 6) begin
			big = $urandom;
			if (big <= MAX_CHUNKS)
				big = big + MAX_CHUNKS + 1;
			send_start(big, 16'($urandom_range(0, 65535)), nc);
			return;
		end
		if (pick < 12)
			cnt = MAX_CHUNKS;
		else if (pick < 20)
			cnt = $urandom_range(41, 64);
		else
			cnt = $urandom_range(0, 40);
		send_start(cnt, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)), nc);
		// large transfers get only a handful of chunks
		if (cnt > 300) begin
			for (j = 0; j < 6; j++)
				order.push_back($urandom_range(0, cnt - 1));
		end else begin
			for (j = 0; j < cnt; j++)
				order.push_back(j);
			for (j = cnt - 1; j > 0; j--) begin
				k        = $urandom_range(0, j);
				tmp      = order[j];
				order[j] = order[k];
				order[k] = tmp;
			end
		end
		foreach (order[i]) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_noise();
			else if (pick < 11)
				send_end(rx_id, 1'($urandom_range(0, 1)));
			else if (pick < 13)
				send_start(cnt, 16'($urandom_range(0, 65535)), nc);
			if ($urandom_range(0, 99) >= 10)
				send_data(rx_id, order[i]);
			if ($urandom_range(0, 99) < 10)
				send_data(rx_id, order[i]);
		end
		send_end(rx_id, $urandom_range(0, 3) != 0);
		// fill every gap left after the nak run and close again
		if (cnt <= 300) begin
			for (k = 0; k < 2 && rx_phase == PH_RECV && rx_count < rx_total; k++) begin
				for (j = 0; j < rx_total; j++)
					if (!rx_map[j])
						send_data(rx_id, j);
				send_end(rx_id, $urandom_range(0, 3) != 0);
			end
		end
		if ($urandom_range(0, 2) == 0)
			send_end(rx_id, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_transfers();
		while (n_sent < LIVE_ITEMS) begin
			run_transfer();
			if ($urandom_range(0, 4) == 0)
				wait_replies();
		end
	endtask

	task automatic match(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	// result side: random stalls plus the counted hold-off
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_if.ready = 1'b0;
				hold_cycles--;
			end else begin
				rsp_if.ready = no_idle || ($urandom_range(0, 99) >= 21);
			end
		end
	end

	always @(posedge clk) begin
		reply_t r;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (reply_q.size() == 0) begin
				$error("result beat with nothing outstanding, kind %0d", rsp_if.kind);
				errs++;
			end else begin
				r = reply_q.pop_front();
				match("kind", r.kind, rsp_if.kind);
				match("ack_transfer_id", r.id, rsp_if.ack_transfer_id);
				match("echo_nonce", r.nonce, rsp_if.echo_nonce);
				match("missing_seq", r.miss, rsp_if.missing_seq);
				match("received_count", r.rcvd, rsp_if.received_count);
				match("last", r.last, rsp_if.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.opcode       = '0;
		req_if.xfer_id      = '0;
		req_if.chunk_seq    = '0;
		req_if.chunk_count  = '0;
		req_if.start_nonce  = '0;
		req_if.candidate_id = '0;
		req_if.crc_ok       = 1'b0;
		errs        = 0;
		n_sent      = 0;
		hold_cycles = 0;
		no_idle     = 1'b0;
		wipe_context();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_stray_items();
		test_start_limits();
		test_full_range();
		test_pass_path();
		wait_replies();
		test_burst();
		test_output_stall();
		test_random_transfers();

		wait_replies();
		// let a trailing clearing sweep or dropped item run out
		repeat (300) @(posedge clk);
		if (errs == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ctrt_pkg.sv
hw/rtl/ctrt_if.sv
hw/rtl/chunk_transfer_receiver_tracker.sv
tb/sv/tb_chunk_transfer_receiver_tracker.sv
